// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each macro takes a label, a clock, a reset that disables the check,
// an antecedent, a consequent and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mpq_pkg.sv =====
`timescale 1ns / 1ps

package mpq_pkg;

   localparam int VALUE_W  = 31;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic enqueue;
      logic reply_empty;
      logic scan_start;
      logic scan_read;
      logic release_best;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic scan_last;
   } stat_type;

endpackage

// ===== design/mpq_ctrl.sv =====
`timescale 1ns / 1ps

module mpq_ctrl
   import mpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_mode,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;
   localparam logic [1:0] ST_FINAL   = 2'd2;
   localparam logic [1:0] ST_RELEASE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode == MODE_ENQ) begin
                  cmd.enqueue = 1'b1;
               end else if (stat.empty) begin
                  cmd.reply_empty = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_FINAL;
            end
         end
         // The last slot read is compared in this state.
         ST_FINAL: begin
            state_in = ST_RELEASE;
         end
         ST_RELEASE: begin
            cmd.release_best = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== design/mpq_dp.sv =====
`timescale 1ns / 1ps

module mpq_dp
   import mpq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [VALUE_W-1:0]  req_in_value,
   output stat_type            stat,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_out_value,
   output logic [COUNT_W-1:0]  rsp_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [VALUE_W-1:0]  slot_mem [DEPTH];

   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic                rd_valid_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                cmp_en_ff;
   logic                best_found_ff, best_found_in;
   logic [VALUE_W-1:0]  best_value_ff, best_value_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_out_value_ff, rsp_out_value_in;
   logic [COUNT_W-1:0]  rsp_occupancy_ff;

   logic [IDX_W-1:0]    free_idx;
   logic                full;
   logic                take;

   // Lowest-index free slot.
   always_comb begin
      free_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign full           = &valid_ff;
   assign stat.empty     = ~|valid_ff;
   assign stat.scan_last = (scan_idx_ff == IDX_W'(DEPTH - 1));

   // Strictly greater keeps the lowest index on ties.
   assign take = cmp_en_ff && rd_valid_ff && (!best_found_ff || (rd_data_ff > best_value_ff));

   always_comb begin
      valid_in         = valid_ff;
      count_in         = count_ff;
      scan_idx_in      = scan_idx_ff;
      best_found_in    = best_found_ff;
      best_value_in    = best_value_ff;
      best_idx_in      = best_idx_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = STATUS_DONE;
      rsp_out_value_in = '0;

      if (cmd.scan_start) begin
         scan_idx_in   = '0;
         best_found_in = 1'b0;
      end
      if (cmd.scan_read) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (take) begin
         best_found_in = 1'b1;
         best_value_in = rd_data_ff;
         best_idx_in   = rd_idx_ff;
      end

      if (cmd.enqueue) begin
         rsp_strobe_in = 1'b1;
         if (full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            valid_in[free_idx] = 1'b1;
            count_in           = count_ff + 1'b1;
         end
      end
      if (cmd.reply_empty) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = STATUS_EMPTY;
      end
      if (cmd.release_best) begin
         rsp_strobe_in         = 1'b1;
         valid_in[best_idx_ff] = 1'b0;
         count_in              = count_ff - 1'b1;
         rsp_out_value_in      = best_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enqueue && !full) begin
         slot_mem[free_idx] <= req_in_value;
      end
      rd_data_ff <= slot_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      rd_valid_ff   <= valid_ff[scan_idx_ff];
      rd_idx_ff     <= scan_idx_ff;
      best_value_ff <= best_value_in;
      best_idx_ff   <= best_idx_in;
      if (rsp_strobe_in) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_out_value_ff <= rsp_out_value_in;
         rsp_occupancy_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         cmp_en_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_en_ff     <= cmd.scan_read;
         best_found_ff <= best_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_out_value_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

// ===== design/max_priority_queue.sv =====
`timescale 1ns / 1ps

// Bounded max-priority queue of DEPTH slots holding 31-bit unsigned values. An item is
// taken at a rising edge where start is high and busy is low; req_mode 0 enqueues
// req_in_value into the lowest free slot, req_mode 1 removes the largest stored value,
// the lowest-index slot winning on ties. Every item gives exactly one result, shown for
// a single cycle with rsp_strobe high; the receiver cannot stall it, so it must take the
// result in that cycle. rsp_status is done, full (enqueue with every slot taken) or
// empty (dequeue with nothing stored); rsp_out_value carries the removed value and is
// zero otherwise; rsp_occupancy is the count held after the item, kept modulo 16.
// An enqueue, and a dequeue of an empty queue, show their result in the cycle after
// acceptance and busy never rises, so one item per cycle is taken. A dequeue reads the
// slot memory one entry per cycle through a single comparator; busy stays high through
// the scan state, which reads each slot in turn, the final state, which compares the
// last entry read, and the release state, which frees the winning slot. The result
// appears in the cycle in which busy falls, when the next item may already be taken.
// No clearing pass runs after reset; the queue is usable in the first cycle after it.
module max_priority_queue
   import mpq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [VALUE_W-1:0]  req_in_value,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_out_value,
   output logic [COUNT_W-1:0]  rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences each item; it sees only whether the queue is empty and
   // where the scan stands.
   mpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the slot memory, the valid bits, the count, the running
   // maximum of a scan and the result registers.
   mpq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_in_value  (req_in_value),
      .stat          (stat),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

// ===== design/mpq_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpq_checker
   import mpq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_mode,
   input logic                rsp_strobe,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_out_value,
   input logic [COUNT_W-1:0]  rsp_occupancy
);

   `ASSERT_NEXT(a_enq_reply, clock, reset, start && !busy && (req_mode == MODE_ENQ), rsp_strobe && !busy, "enqueue did not answer in the next cycle")
   `ASSERT_NEXT(a_deq_progress, clock, reset, start && !busy && (req_mode == MODE_DEQ), busy || rsp_strobe, "dequeue neither answered nor went busy")
   `ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result shown while busy")
   `ASSERT_SAME(a_empty_reply, clock, reset, rsp_strobe && (rsp_status == STATUS_EMPTY), (rsp_out_value == '0) && (rsp_occupancy == '0), "empty reply carries a value or a count")
   `ASSERT_SAME(a_full_reply, clock, reset, rsp_strobe && (rsp_status == STATUS_FULL), rsp_out_value == '0, "full reply carries a value")

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_mode      (req_mode),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_out_value (rsp_out_value),
   .rsp_occupancy (rsp_occupancy)
);

// ===== sim/max_priority_queue_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bounded max-priority queue.
//
// Commands are built up front into a list by the initial block: a short directed
// part (empty dequeue, extreme values, repeated values, filling to capacity,
// enqueue while full, draining to empty), then about 600 random commands in
// blocks. Each block leans toward enqueues, dequeues or an even mix, so the queue
// often runs full and empty. The driver presents one command at a time on start
// and keeps it there until the block takes it (start high, busy low). At that
// edge a shadow copy of the queue predicts the reply. The monitor compares every
// strobed reply, field by field, with the oldest prediction.
module max_priority_queue_tb;
   import mpq_pkg::*;

   localparam int DEPTH        = 8;
   localparam int RANDOM_ITEMS = 600;
   localparam int BLOCK_ITEMS  = 30;
   // Neither the slowest reply, a dequeue, nor the longest sender gap comes near
   // QUIET_LIMIT, so a quiet spell that long can only mean a hang.
   localparam int QUIET_LIMIT  = 1000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic               mode;
      logic [VALUE_W-1:0] value;
      int unsigned        gap;    // idle cycles before this command is shown
      bit                 drain;  // hold the command until every reply is back
   } queue_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  occupancy;
   } queue_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_mode = MODE_ENQ;
   logic [VALUE_W-1:0]  req_in_value = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_out_value;
   logic [COUNT_W-1:0]  rsp_occupancy;

   // Commands not yet shown to the block, and replies predicted but not yet seen.
   queue_cmd_type   pending_cmds[$];
   queue_reply_type pending_replies[$];

   // Shadow copy of the queue contents, updated as each command is taken.
   logic [VALUE_W-1:0] shadow_value[DEPTH];
   bit                 shadow_used[DEPTH];
   logic [COUNT_W-1:0] shadow_count = '0;

   int unsigned gap_left     = 0;
   int unsigned quiet_cycles = 0;
   int unsigned error_count  = 0;
   int unsigned replies_seen = 0;
   int unsigned enq_stored   = 0;
   int unsigned enq_full     = 0;
   int unsigned deq_taken    = 0;
   int unsigned deq_empty    = 0;
   int unsigned peak_count   = 0;
   bit          timed_out    = 1'b0;

   max_priority_queue #(
      .DEPTH(DEPTH)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_in_value (req_in_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_out_value(rsp_out_value),
      .rsp_occupancy(rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one command to the shadow queue and returns the reply it must give.
   // An enqueue takes the lowest free slot. A dequeue takes the largest value, and
   // the strict compare keeps the lowest slot when values tie.
   function automatic queue_reply_type apply_queue_op(input logic mode,
                                                      input logic [VALUE_W-1:0] value);
      queue_reply_type reply;
      int              best;
      bit              placed;
      reply.status = STATUS_DONE;
      reply.value  = '0;
      best   = -1;
      placed = 1'b0;
      if (mode == MODE_ENQ) begin
         for (int slot = 0; slot < DEPTH; slot++) begin
            if (!placed && !shadow_used[slot]) begin
               shadow_value[slot] = value;
               shadow_used[slot]  = 1'b1;
               placed = 1'b1;
            end
         end
         if (placed) begin
            shadow_count = shadow_count + 1'b1;
            enq_stored++;
         end else begin
            reply.status = STATUS_FULL;
            enq_full++;
         end
      end else begin
         for (int slot = 0; slot < DEPTH; slot++) begin
            if (shadow_used[slot] && (best < 0 || shadow_value[slot] > shadow_value[best])) begin
               best = slot;
            end
         end
         if (best < 0) begin
            reply.status = STATUS_EMPTY;
            deq_empty++;
         end else begin
            reply.value = shadow_value[best];
            shadow_used[best] = 1'b0;
            shadow_count = shadow_count - 1'b1;
            deq_taken++;
         end
      end
      reply.occupancy = shadow_count;
      if (32'(shadow_count) > peak_count) begin
         peak_count = 32'(shadow_count);
      end
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned index,
                                  input logic [31:0] want, input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("Mismatch on reply %0d, %s: expected 0x%0h, got 0x%0h",
                  index, what, want, got);
      end
   endtask

   task automatic add_cmd(input logic mode, input logic [VALUE_W-1:0] value,
                          input int unsigned gap, input bit drain);
      queue_cmd_type cmd;
      cmd.mode  = mode;
      cmd.value = value;
      cmd.gap   = gap;
      cmd.drain = drain;
      pending_cmds.push_back(cmd);
   endtask

   // Most commands have no gap before them; the others get a random gap, now and
   // then a long one. A calm block has no gaps at all, so commands arrive back to back.
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 95) begin
         return $urandom_range(4, 8);
      end else begin
         return $urandom_range(12, 30);
      end
   endfunction

   // Small values make ties common. Extremes and full-width random values cover
   // every bit of the field.
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 3) begin
         return VALUE_W'($urandom_range(0, 7));
      end else if (roll == 3) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(VALUE_W-1){1'b0}}};
            default: return {1'b0, {(VALUE_W-1){1'b1}}};
         endcase
      end else begin
         return VALUE_W'($urandom);
      end
   endfunction

   // Driver. A command stays on the request ports until the block takes it. After
   // that the next command is loaded, or start is lowered for its gap. A command
   // marked drain is held back until every outstanding reply has been checked.
   always @(posedge clock) begin : drive
      queue_cmd_type next_cmd;
      bit            taken;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            pending_replies.push_back(apply_queue_op(req_mode, req_in_value));
         end
         if (start && !taken) begin
            // The block is busy and the same command stays on the ports.
         end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() == 0) begin
            start <= 1'b0;
         end else if (pending_cmds[0].gap != 0) begin
            start    <= 1'b0;
            gap_left <= pending_cmds[0].gap - 1;
            pending_cmds[0].gap = 0;
         end else if (pending_cmds[0].drain && pending_replies.size() != 0) begin
            start <= 1'b0;
         end else begin
            next_cmd = pending_cmds.pop_front();
            start        <= 1'b1;
            req_mode     <= next_cmd.mode;
            req_in_value <= next_cmd.value;
         end
      end
   end

   // Monitor. The receiver cannot stall, so each strobe is checked at the edge that
   // ends it.
   always @(posedge clock) begin : watch_replies
      queue_reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected reply, status", replies_seen, 32'hx,
                            32'(rsp_status));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", replies_seen, 32'(want.status),
                               32'(rsp_status));
            end
            if (rsp_out_value !== want.value) begin
               report_mismatch("out_value", replies_seen, 32'(want.value),
                               32'(rsp_out_value));
            end
            if (rsp_occupancy !== want.occupancy) begin
               report_mismatch("occupancy", replies_seen, 32'(want.occupancy),
                               32'(rsp_occupancy));
            end
         end
         replies_seen++;
      end
   end

   // Watchdog. The count restarts whenever either side completes a handshake.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned enq_pct;
      bit          calm;
      bit          drain;
      logic        mode;

      for (int slot = 0; slot < DEPTH; slot++) begin
         shadow_value[slot] = '0;
         shadow_used[slot]  = 1'b0;
      end

      // Directed part. The queue starts with a dequeue while empty. It is then
      // filled with extremes and repeated values, and the next two enqueues find it
      // full. Draining it must return the values in descending order, and one more
      // dequeue finds it empty again.
      add_cmd(MODE_DEQ, '1, 0, 1'b0);
      add_cmd(MODE_ENQ, '0, 0, 1'b0);
      add_cmd(MODE_ENQ, '1, 1, 1'b0);
      add_cmd(MODE_ENQ, VALUE_W'(5), 0, 1'b0);
      add_cmd(MODE_ENQ, VALUE_W'(5), 0, 1'b0);
      add_cmd(MODE_ENQ, '0, 2, 1'b0);
      add_cmd(MODE_ENQ, '1, 0, 1'b0);
      add_cmd(MODE_ENQ, VALUE_W'(1), 0, 1'b0);
      add_cmd(MODE_ENQ, {1'b1, {(VALUE_W-1){1'b0}}}, 0, 1'b0);
      add_cmd(MODE_ENQ, VALUE_W'(123), 0, 1'b0);
      add_cmd(MODE_ENQ, {1'b0, {(VALUE_W-1){1'b1}}}, 0, 1'b0);
      for (int n = 0; n < DEPTH; n++) begin
         add_cmd(MODE_DEQ, (n % 2 == 0) ? '0 : '1, n % 3, 1'b0);
      end
      add_cmd(MODE_DEQ, '0, 0, 1'b0);
      add_cmd(MODE_ENQ, VALUE_W'(9), 0, 1'b0);
      add_cmd(MODE_DEQ, '0, 0, 1'b0);

      // Random part, in blocks that lean toward filling, draining or holding the
      // level. The first command of every fourth block waits for all replies.
      for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         case ($urandom_range(0, 3))
            0: enq_pct = 85;
            1: enq_pct = 15;
            default: enq_pct = 50;
         endcase
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            drain = (n == 0) && (blk % 4 == 0);
            mode  = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
            add_cmd(mode, pick_value(), pick_gap(calm), drain);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && (pending_cmds.size() != 0 || start || pending_replies.size() != 0)) begin
         @(posedge clock);
         if (quiet_cycles >= QUIET_LIMIT) begin
            timed_out = 1'b1;
         end
      end

      if (timed_out) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      end else begin
         // Let a stray reply show up before the books are closed.
         repeat (DEPTH + 4) @(posedge clock);
      end
      while (pending_replies.size() != 0) begin
         void'(pending_replies.pop_front());
         report_mismatch("missing reply, count", replies_seen, 1, 0);
      end

      $display("Checked %0d replies: %0d stored, %0d refused as full, %0d removed, %0d empty",
               replies_seen, enq_stored, enq_full, deq_taken, deq_empty);
      $display("Peak occupancy %0d of %0d, %0d mismatches", peak_count, DEPTH, error_count);
      if (!timed_out && error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
